[sv/rc5_irtx_pkg.sv]
package rc5_irtx_pkg;

  localparam int FrameBits = 14;
  localparam int AddrW     = 5;
  localparam int CmdW      = 7;
  localparam int CarrierW  = 8;
  localparam int HalfBitW  = 16;
  localparam int GapW      = 20;
  localparam int CfgDataW  = 20;
  localparam int CfgIdxW   = 3;
  localparam int BitIdxW   = 4;

  // Register indexes on the configuration port
  localparam logic [CfgIdxW-1:0] CfgDeviceAddress   = 3'd0;
  localparam logic [CfgIdxW-1:0] CfgCarrierPeriod   = 3'd1;
  localparam logic [CfgIdxW-1:0] CfgCarrierDuty     = 3'd2;
  localparam logic [CfgIdxW-1:0] CfgHalfBitTicks    = 3'd3;
  localparam logic [CfgIdxW-1:0] CfgRepeatGapTicks  = 3'd4;

  // Reset values of the registers
  localparam logic [AddrW-1:0]    DeviceAddressRst = 5'd0;
  localparam logic [CarrierW-1:0] CarrierTopRst    = 8'd32;
  localparam logic [CarrierW-1:0] CarrierDutyRst   = 8'd7;
  localparam logic [HalfBitW-1:0] HalfBitRst       = 16'd1067;
  localparam logic [GapW-1:0]     RepeatGapRst     = 20'd106800;

  typedef struct packed {
    logic            key_held;
    logic [CmdW-1:0] command;
  } tick_in_t;

  typedef struct packed {
    logic ir_drive;
    logic mark_envelope;
    logic busy_res;
    logic frame_last;
  } tick_out_t;

endpackage

[sv/rc5_ir_frame_transmitter.sv]
// Extended RC-5 infrared transmitter driven by one input transaction per time tick. While idle,
// a tick with key_held set latches a 14-bit frame (start bit, inverted command bit 6, toggle,
// 5-bit device address, command bits 5..0) and sending begins on that tick. Each bit goes out
// Manchester coded, MSB first, as two half-bits of half_bit_ticks ticks (1 = space then mark,
// 0 = mark then space); marks are gated by a free-running carrier of period
// carrier_period_top + 1 that is on while its counter is at or below carrier_duty_count. Every
// frame is followed by repeat_gap_ticks ticks of gap; a key still held at the gap's end resends
// the same frame, otherwise the toggle bit flips and the block goes idle. Each input transaction
// yields exactly one result transaction. A tick is accepted whenever the output register is empty or
// being taken, and its result is registered there; the output register is the only stage, so
// throughput is one tick per cycle for as long as the result side keeps taking. Configuration
// writes take effect at once and should be made while no tick is in flight.
module rc5_ir_frame_transmitter #(
  parameter int TIMER_BITS = 20
) (
  input  logic                                  clk_i,
  input  logic                                  rst_ni,
  input  logic                                  cfg_we_i,
  input  logic [rc5_irtx_pkg::CfgIdxW-1:0]      cfg_index_i,
  input  logic [rc5_irtx_pkg::CfgDataW-1:0]     cfg_data_i,
  input  logic                                  in_valid_i,
  output logic                                  in_ready_o,
  input  rc5_irtx_pkg::tick_in_t                in_data_i,
  output logic                                  out_valid_o,
  input  logic                                  out_ready_i,
  output rc5_irtx_pkg::tick_out_t               out_data_o
);
  import rc5_irtx_pkg::*;

  localparam int CmpW = ((TIMER_BITS > GapW) ? TIMER_BITS : GapW) + 1;

  typedef enum logic [1:0] {
    PH_IDLE = 2'd0,
    PH_SEND = 2'd1,
    PH_GAP  = 2'd2
  } phase_e;

  // Configuration
  logic [AddrW-1:0]    dev_addr_q;
  logic [CarrierW-1:0] carrier_top_q;
  logic [CarrierW-1:0] carrier_duty_q;
  logic [HalfBitW-1:0] half_bit_q;
  logic [GapW-1:0]     gap_q;

  // Transmitter state
  phase_e                 phase_q, phase_d;
  logic [FrameBits-1:0]   frame_q, frame_d;
  logic [BitIdxW-1:0]     bit_idx_q, bit_idx_d;
  logic                   second_half_q, second_half_d;
  logic [TIMER_BITS-1:0]  timer_q, timer_d;
  logic [CarrierW-1:0]    carrier_q, carrier_d;
  logic                   toggle_q, toggle_d;

  logic                   out_valid_q;
  tick_out_t              out_data_q, out_data_d;

  logic                   in_fire;

  function automatic logic interval_end(input logic [TIMER_BITS-1:0] t,
                                        input logic [CmpW-1:0] len);
    logic [CmpW-1:0] lim;
    logic [CmpW-1:0] nxt;
    lim = (len == '0) ? CmpW'(1) : len;
    nxt = CmpW'(t) + CmpW'(1);
    return (nxt >= lim) || (t == '1);
  endfunction

  assign in_ready_o  = !out_valid_q || out_ready_i;
  assign in_fire     = in_valid_i && in_ready_o;
  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_data_q;

  always_comb begin
    logic                 carrier_on;
    logic                 mark;
    logic                 busy;
    logic                 last;
    logic                 cur_bit;
    logic [BitIdxW-1:0]   sel;

    phase_d       = phase_q;
    frame_d       = frame_q;
    bit_idx_d     = bit_idx_q;
    second_half_d = second_half_q;
    timer_d       = timer_q;
    toggle_d      = toggle_q;
    mark          = 1'b0;
    busy          = 1'b0;
    last          = 1'b0;
    cur_bit       = 1'b0;
    sel           = '0;

    carrier_on = (carrier_q <= carrier_duty_q);
    carrier_d  = (carrier_q >= carrier_top_q) ? '0 : carrier_q + CarrierW'(1);

    // Idle (and the unused phase code): on a held key, latch a frame and start on this tick
    if (phase_q != PH_SEND && phase_q != PH_GAP) begin
      phase_d = PH_IDLE;
      if (in_data_i.key_held) begin
        frame_d       = {1'b1, ~in_data_i.command[CmdW-1], toggle_q, dev_addr_q,
                         in_data_i.command[CmdW-2:0]};
        phase_d       = PH_SEND;
        bit_idx_d     = '0;
        second_half_d = 1'b0;
        timer_d       = '0;
      end
    end

    if (phase_d == PH_SEND) begin
      busy = 1'b1;
      if (bit_idx_d >= BitIdxW'(FrameBits)) begin
        phase_d = PH_GAP;
        timer_d = '0;
        last    = 1'b1;
      end else begin
        sel     = BitIdxW'(FrameBits - 1) - bit_idx_d;
        cur_bit = frame_d[sel];
        mark    = (cur_bit == second_half_d);
        if (interval_end(timer_d, CmpW'(half_bit_q))) begin
          timer_d = '0;
          if (second_half_d) begin
            second_half_d = 1'b0;
            if (bit_idx_d == BitIdxW'(FrameBits - 1)) begin
              last      = 1'b1;
              phase_d   = PH_GAP;
              bit_idx_d = '0;
            end else begin
              bit_idx_d = bit_idx_d + BitIdxW'(1);
            end
          end else begin
            second_half_d = 1'b1;
          end
        end else begin
          timer_d = timer_d + TIMER_BITS'(1);
        end
      end
    end else if (phase_d == PH_GAP) begin
      busy = 1'b1;
      if (interval_end(timer_d, CmpW'(gap_q))) begin
        timer_d = '0;
        if (in_data_i.key_held) begin
          // repeat the same frame, command is not relatched
          phase_d       = PH_SEND;
          bit_idx_d     = '0;
          second_half_d = 1'b0;
        end else begin
          toggle_d = ~toggle_q;
          phase_d  = PH_IDLE;
        end
      end else begin
        timer_d = timer_d + TIMER_BITS'(1);
      end
    end

    out_data_d.ir_drive      = mark & carrier_on;
    out_data_d.mark_envelope = mark;
    out_data_d.busy_res      = busy;
    out_data_d.frame_last    = last;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      dev_addr_q     <= DeviceAddressRst;
      carrier_top_q  <= CarrierTopRst;
      carrier_duty_q <= CarrierDutyRst;
      half_bit_q     <= HalfBitRst;
      gap_q          <= RepeatGapRst;
      phase_q        <= PH_IDLE;
      frame_q        <= '0;
      bit_idx_q      <= '0;
      second_half_q  <= 1'b0;
      timer_q        <= '0;
      carrier_q      <= '0;
      toggle_q       <= 1'b0;
      out_valid_q    <= 1'b0;
      out_data_q     <= '0;
    end else begin
      if (cfg_we_i) begin
        unique case (cfg_index_i)
          CfgDeviceAddress:  dev_addr_q     <= cfg_data_i[AddrW-1:0];
          CfgCarrierPeriod:  carrier_top_q  <= cfg_data_i[CarrierW-1:0];
          CfgCarrierDuty:    carrier_duty_q <= cfg_data_i[CarrierW-1:0];
          CfgHalfBitTicks:   half_bit_q     <= cfg_data_i[HalfBitW-1:0];
          CfgRepeatGapTicks: gap_q          <= cfg_data_i[GapW-1:0];
          default: ;
        endcase
      end
      if (in_fire) begin
        phase_q       <= phase_d;
        frame_q       <= frame_d;
        bit_idx_q     <= bit_idx_d;
        second_half_q <= second_half_d;
        timer_q       <= timer_d;
        carrier_q     <= carrier_d;
        toggle_q      <= toggle_d;
        out_valid_q   <= 1'b1;
        out_data_q    <= out_data_d;
      end else if (out_ready_i) begin
        out_valid_q   <= 1'b0;
      end
    end
  end

endmodule

[sv/rc5_irtx_chk.sv]
module rc5_irtx_chk (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  logic                     in_valid_i,
  input  logic                     in_ready_o,
  input  logic                     out_valid_o,
  input  logic                     out_ready_i,
  input  rc5_irtx_pkg::tick_out_t  out_data_o
);
  import rc5_irtx_pkg::*;

  // A stalled result transaction stays offered
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && !out_ready_i) |=> out_valid_o)
    else $error("result transaction dropped while stalled");

  // Output register full and not taken: no new tick may enter
  a_stall_blocks_input: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && !out_ready_i) |-> !in_ready_o)
    else $error("input accepted while result stalled");

  // The LED is driven only inside a mark
  a_drive_in_mark: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && out_data_o.ir_drive) |-> out_data_o.mark_envelope)
    else $error("carrier driven outside a mark");

  // Marks and frame end only while busy
  a_mark_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && (out_data_o.mark_envelope || out_data_o.frame_last))
      |-> out_data_o.busy_res)
    else $error("mark or frame end while idle");

  // A taken frame end is not directly followed by another marked frame end
  a_gap_after_frame: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && out_ready_i && out_data_o.frame_last) |=>
      (!out_valid_o || !out_data_o.mark_envelope || !out_data_o.frame_last))
    else $error("frame end repeated on consecutive results");

endmodule

bind rc5_ir_frame_transmitter rc5_irtx_chk u_rc5_irtx_chk (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .in_valid_i  (in_valid_i),
  .in_ready_o  (in_ready_o),
  .out_valid_o (out_valid_o),
  .out_ready_i (out_ready_i),
  .out_data_o  (out_data_o)
);
